// ===== hw/rtl/mqsb_pkg.sv =====
// Shared constants and types for the multi-queue shared buffer.
// Used by mqsb_ctrl, mqsb_datapath and multi_queue_shared_buffer.
`default_nettype none

package mqsb_pkg;

    localparam int NUM_QUEUES = 4;
    localparam int SLOTS      = 16;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths of the ports
    localparam int CMD_W    = 1;
    localparam int QID_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // Slot index and pointer widths; a pointer equal to SLOTS is null
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W  = $clog2(SLOTS + 1);
    localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int QSEL_W = (QIDX_W > QID_W) ? QIDX_W : QID_W;
    localparam int EXT_W  = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(SLOTS);

    localparam logic [CMD_W-1:0] CMD_ENQ = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic signed [VALUE_W-1:0] POP_NONE = -32'sd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic exec;      // perform the operation on the input fields
        logic load_out;  // load the result into the output register
    } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/multi_queue_shared_buffer.sv =====
// A result is offered once its operation has passed from S_IDLE through S_WB into the
// output register; S_WB waits while an earlier result is still held. One operation is in
// flight at a time: in_stall is high in S_WB, and the pointer update and the registered
// read of the value memory both happen at the exec step. A held result does not block the next input transfer.
// Reset (rst_n, async low): all queues empty, every slot on the free list.
// Top level of the multi-queue shared buffer; uses mqsb_pkg, mqsb_ctrl, mqsb_datapath.
`default_nettype none

module multi_queue_shared_buffer (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [mqsb_pkg::CMD_W-1:0]           cmd,
    input  wire logic [mqsb_pkg::QID_W-1:0]           queue_id,
    input  wire logic signed [mqsb_pkg::VALUE_W-1:0]  push_value,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [mqsb_pkg::STATUS_W-1:0]             status,
    output logic signed [mqsb_pkg::VALUE_W-1:0]       pop_value
);
    import mqsb_pkg::*;

    ctrl_cmd_t ctrl;

    mqsb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl)
    );

    mqsb_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cmd        (cmd),
        .queue_id   (queue_id),
        .push_value (push_value),
        .status     (status),
        .pop_value  (pop_value)
    );

`ifndef ASSERT_OFF
    // Only one operation in flight: an input transfer is followed by a busy cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an operation is in flight");

    // A refused operation returns no value
    a_refused_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_DONE) |-> (pop_value == POP_NONE))
        else $error("refused operation returned a value");

    // A result is only loaded while an executed operation is still in flight
    a_result_follows_op: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |-> in_stall)
        else $error("result loaded without an operation");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mqsb_datapath.sv =====
// Datapath of the multi-queue shared buffer: pointers, link store, value
// memory and output register. Depends on mqsb_pkg.
`default_nettype none

module mqsb_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire mqsb_pkg::ctrl_cmd_t                  ctrl,
    input  wire logic [mqsb_pkg::CMD_W-1:0]           cmd,
    input  wire logic [mqsb_pkg::QID_W-1:0]           queue_id,
    input  wire logic signed [mqsb_pkg::VALUE_W-1:0]  push_value,
    output logic [mqsb_pkg::STATUS_W-1:0]             status,
    output logic signed [mqsb_pkg::VALUE_W-1:0]       pop_value
);
    import mqsb_pkg::*;

    logic [PTR_W-1:0] head_reg [NUM_QUEUES];
    logic [PTR_W-1:0] head_next [NUM_QUEUES];
    logic [PTR_W-1:0] tail_reg [NUM_QUEUES];
    logic [PTR_W-1:0] tail_next [NUM_QUEUES];
    logic [PTR_W-1:0] link_reg [SLOTS];
    logic [PTR_W-1:0] link_next [SLOTS];
    logic [PTR_W-1:0] free_head_reg;
    logic [PTR_W-1:0] free_head_next;

    logic [DATA_WIDTH-1:0] value_mem [SLOTS];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [STATUS_W-1:0]          pend_status_reg;
    logic                         pend_pop_reg;
    logic [STATUS_W-1:0]          status_reg;
    logic signed [VALUE_W-1:0]    pop_value_reg;

    logic [QSEL_W-1:0]            q_ext;
    logic [QIDX_W-1:0]            q_idx;
    logic                         q_ok;
    logic [PTR_W-1:0]             cur_head;
    logic [PTR_W-1:0]             cur_tail;
    logic [PTR_W-1:0]             deq_next_head;
    logic                         head_ok;
    logic                         tail_ok;
    logic                         free_ok;
    logic                         enq_ok;
    logic                         deq_ok;
    logic [IDX_W-1:0]             free_idx;
    logic [IDX_W-1:0]             head_idx;
    logic [STATUS_W-1:0]          op_status;
    logic signed [EXT_W-1:0]      push_ext;
    logic signed [EXT_W-1:0]      rd_ext;

    assign q_ext    = QSEL_W'(queue_id);
    assign q_idx    = q_ext[QIDX_W-1:0];
    assign q_ok     = {1'b0, q_ext} < (QSEL_W + 1)'(NUM_QUEUES);
    assign cur_head = head_reg[q_idx];
    assign cur_tail = tail_reg[q_idx];
    assign head_ok  = cur_head < PTR_NULL;
    assign tail_ok  = cur_tail < PTR_NULL;
    assign free_ok  = free_head_reg < PTR_NULL;
    assign free_idx = free_head_reg[IDX_W-1:0];
    assign head_idx = cur_head[IDX_W-1:0];
    assign deq_next_head = link_reg[head_idx];

    assign enq_ok = ctrl.exec && (cmd == CMD_ENQ) && q_ok && free_ok;
    assign deq_ok = ctrl.exec && (cmd == CMD_DEQ) && q_ok && head_ok;

    assign push_ext = EXT_W'(push_value);
    assign rd_ext   = EXT_W'(signed'(rd_data_reg));

    always_comb
    begin
        unique case (cmd)
            CMD_ENQ: op_status = (q_ok && free_ok) ? ST_DONE : ST_FULL;
            CMD_DEQ: op_status = (q_ok && head_ok) ? ST_DONE : ST_EMPTY;
            default: op_status = ST_EMPTY;
        endcase
    end

    // Pointer and link updates for one operation
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        link_next      = link_reg;
        free_head_next = free_head_reg;
        if (enq_ok)
        begin
            free_head_next = link_reg[free_idx];
            if (!head_ok)
            begin
                head_next[q_idx] = free_head_reg;
            end
            else if (tail_ok)
            begin
                link_next[cur_tail[IDX_W-1:0]] = free_head_reg;
            end
            tail_next[q_idx]    = free_head_reg;
            link_next[free_idx] = PTR_NULL;
        end
        else if (deq_ok)
        begin
            head_next[q_idx] = deq_next_head;
            if (!(deq_next_head < PTR_NULL))
            begin
                tail_next[q_idx] = PTR_NULL;
            end
            link_next[head_idx] = free_head_reg;
            free_head_next      = cur_head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= PTR_NULL;
                tail_reg[i] <= PTR_NULL;
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                link_reg[i] <= (i + 1 < SLOTS) ? PTR_W'(i + 1) : PTR_NULL;
            end
            free_head_reg <= '0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            link_reg      <= link_next;
            free_head_reg <= free_head_next;
        end
    end

    // Value memory: write on enqueue, registered read on dequeue
    always_ff @(posedge clk)
    begin
        if (enq_ok)
        begin
            value_mem[free_idx] <= push_ext[DATA_WIDTH-1:0];
        end
        if (deq_ok)
        begin
            rd_data_reg <= value_mem[head_idx];
        end
    end

    // Hold the outcome until the read data is back, then load the output
    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            pend_status_reg <= op_status;
            pend_pop_reg    <= deq_ok;
        end
        if (ctrl.load_out)
        begin
            status_reg    <= pend_status_reg;
            pop_value_reg <= pend_pop_reg ? rd_ext[VALUE_W-1:0] : POP_NONE;
        end
    end

    assign status    = status_reg;
    assign pop_value = pop_value_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mqsb_ctrl.sv =====
// Controller of the multi-queue shared buffer: sequences one operation
// and owns both handshakes. Depends on mqsb_pkg.
`default_nettype none

module mqsb_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  wire logic           out_stall,
    output mqsb_pkg::ctrl_cmd_t ctrl
);
    import mqsb_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_WB
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctrl           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.exec  = 1'b1;
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                // Wait here while an earlier result is still held
                if (out_free)
                begin
                    ctrl.load_out  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
